// ----- hw/rtl/ikc_pkg.sv -----
package ikc_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int MaxKernel = 7;
  localparam int CoefBits  = 16;
  localparam int KernDepth = MaxKernel * MaxKernel;
  localparam int FrameDepth = MaxWidth * MaxHeight;
  localparam int FrameAw   = $clog2(FrameDepth);
  localparam int KernAw    = $clog2(KernDepth);
  localparam int AccBits   = 32;
  localparam int TotBits   = 22;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    CmdCoef    = 2'd0,
    CmdPixel   = 2'd1,
    CmdCompute = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegKsize  = 2'd2,
    RegBorder = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    BorderClamp  = 2'd0,
    BorderWrap   = 2'd1,
    BorderMirror = 2'd2,
    BorderOther  = 2'd3
  } border_e;

  typedef enum logic [2:0] {
    StIdle,
    StTap,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [31:0]        pixel_in;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [5:0]  out_x;
    logic [5:0]  out_y;
    logic        size_error;
  } out_t;

  typedef struct packed {
    logic [5:0] pos_x;
    logic [5:0] pos_y;
  } job_t;

  // Map a signed coordinate into 0..dim-1 by the border rule.
  function automatic logic [5:0] map_coord(input logic signed [8:0] c,
                                           input logic [6:0] dim,
                                           input logic [1:0] mode);
    logic signed [11:0] v;
    logic signed [11:0] d;
    begin
      d = $signed({5'b00000, dim});
      v = 12'(c);
      if (mode == BorderWrap) begin
        if (v < 0) v = v + d;
        else begin
          for (int s = 4; s >= 0; s--) begin
            if (v >= (d <<< s)) v = v - (d <<< s);
          end
        end
      end else if (mode == BorderMirror) begin
        if (v < 0) v = -v;
        else if (v >= d) v = (d <<< 1) - v - 12'sd2;
      end
      if (v < 0) v = '0;
      if (v >= d) v = d - 12'sd1;
      map_coord = v[5:0];
    end
  endfunction

endpackage

// ----- hw/rtl/ikc_ram.sv -----
module ikc_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/ikc_front.sv -----
module ikc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ikc_pkg::in_t                   in_data_i,
  output logic                           frame_we_o,
  output logic [ikc_pkg::FrameAw-1:0]    frame_waddr_o,
  output logic [31:0]                    frame_wdata_o,
  output logic                           coef_we_o,
  output logic [ikc_pkg::KernAw-1:0]     coef_waddr_o,
  output logic signed [15:0]             coef_wdata_o,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  output ikc_pkg::job_t                  job_o
);

  localparam int Qaw = $clog2(ikc_pkg::QueueDepth);

  ikc_pkg::job_t     q_mem_q [ikc_pkg::QueueDepth];
  logic [Qaw-1:0]    wr_q, rd_q;
  logic [Qaw:0]      cnt_q;
  logic              full, accept, push, pop, is_write;

  assign full   = (cnt_q == (Qaw+1)'(ikc_pkg::QueueDepth));
  // Writes wait until queued computes are done so the order holds.
  assign is_write = (in_data_i.cmd == ikc_pkg::CmdCoef) ||
                    (in_data_i.cmd == ikc_pkg::CmdPixel);
  assign in_ready_o = is_write ? (cnt_q == '0 && job_ready_i) : !full;
  assign accept = in_valid_i && in_ready_o;
  assign push   = accept && (in_data_i.cmd == ikc_pkg::CmdCompute);
  assign pop    = job_valid_o && job_ready_i;

  assign frame_we_o    = accept && (in_data_i.cmd == ikc_pkg::CmdPixel);
  assign frame_waddr_o = {in_data_i.pos_y, in_data_i.pos_x};
  assign frame_wdata_o = in_data_i.pixel_in;
  assign coef_we_o     = accept && (in_data_i.cmd == ikc_pkg::CmdCoef) &&
                         (in_data_i.coef_index < 6'(ikc_pkg::KernDepth));
  assign coef_waddr_o  = in_data_i.coef_index[ikc_pkg::KernAw-1:0];
  assign coef_wdata_o  = in_data_i.coef_value;

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= '{pos_x: in_data_i.pos_x, pos_y: in_data_i.pos_y};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + Qaw'(1);
      if (pop)  rd_q <= rd_q + Qaw'(1);
      cnt_q <= cnt_q + (Qaw+1)'(push) - (Qaw+1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/ikc_back.sv -----
module ikc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  ikc_pkg::job_t                job_i,
  input  logic [6:0]                   width_i,
  input  logic [6:0]                   height_i,
  input  logic [2:0]                   ksize_i,
  input  logic [1:0]                   border_i,
  input  logic                         coef_we_i,
  input  logic [ikc_pkg::KernAw-1:0]   coef_waddr_i,
  input  logic signed [15:0]           coef_wdata_i,
  output logic [ikc_pkg::FrameAw-1:0]  frame_raddr_o,
  input  logic [31:0]                  frame_rdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ikc_pkg::out_t                out_data_o
);

  logic [15:0]        kern_rdata;
  logic               kvld_rd_q;
  logic [ikc_pkg::KernDepth-1:0] kvld_q;

  ikc_pkg::state_e    state_q, state_d;
  ikc_pkg::job_t      job_q, job_d;
  logic [2:0]         ti_q, ti_d, tj_q, tj_d;
  logic [2:0]         k_q, k_d;
  logic               rd_pend_q, rd_pend_d;
  logic signed [ikc_pkg::TotBits-1:0] total_q, total_d;
  logic signed [ikc_pkg::AccBits-1:0] acc_q [4];
  logic signed [ikc_pkg::AccBits-1:0] acc_d [4];
  logic [1:0]         ch_q, ch_d;
  logic [5:0]         bit_q, bit_d;
  logic [ikc_pkg::AccBits-1:0] num_q, num_d, rem_q, rem_d;
  logic               neg_q, neg_d;
  logic [31:0]        res_q, res_d;
  logic               err_q, err_d;
  logic               ovalid_q, ovalid_d;
  ikc_pkg::out_t      odata_q, odata_d;

  logic [6:0]         w_eff, h_eff;
  logic [5:0]         kidx;
  logic signed [15:0] kval;
  logic signed [8:0]  cx, cy;
  logic [5:0]         mx, my;
  logic [ikc_pkg::AccBits-1:0] dmag, rem_sh;
  logic signed [ikc_pkg::AccBits-1:0] q_s;
  logic [2:0]         radius;

  assign w_eff = (width_i < 7'd4) ? 7'd4 : (width_i > 7'(ikc_pkg::MaxWidth)) ?
                 7'(ikc_pkg::MaxWidth) : width_i;
  assign h_eff = (height_i < 7'd4) ? 7'd4 : (height_i > 7'(ikc_pkg::MaxHeight)) ?
                 7'(ikc_pkg::MaxHeight) : height_i;
  assign radius = k_q >> 1;
  assign kidx = 6'(tj_q) * 6'(k_q) + 6'(ti_q);
  assign kval = kvld_rd_q ? $signed(kern_rdata) : '0;
  assign cx = $signed({3'b000, job_q.pos_x}) + $signed({6'b0, ti_q}) -
              $signed({6'b0, radius});
  assign cy = $signed({3'b000, job_q.pos_y}) + $signed({6'b0, tj_q}) -
              $signed({6'b0, radius});
  assign mx = ikc_pkg::map_coord(cx, w_eff, border_i);
  assign my = ikc_pkg::map_coord(cy, h_eff, border_i);
  assign frame_raddr_o = {my, mx};
  assign dmag = total_q[ikc_pkg::TotBits-1] ? ikc_pkg::AccBits'(-total_q) :
                ikc_pkg::AccBits'(total_q);
  assign rem_sh = {rem_q[ikc_pkg::AccBits-2:0], num_q[ikc_pkg::AccBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvld_q <= '0;
    end else if (coef_we_i) begin
      kvld_q[coef_waddr_i] <= 1'b1;
    end
  end

  ikc_ram #(.Width(16), .Depth(ikc_pkg::KernDepth)) u_kern (
    .clk_i, .we_i(coef_we_i), .waddr_i(coef_waddr_i), .wdata_i(coef_wdata_i),
    .raddr_i(kidx), .rdata_o(kern_rdata)
  );

  assign job_ready_o = (state_q == ikc_pkg::StIdle);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    logic signed [ikc_pkg::AccBits-1:0] qv;
    qv = '0;
    state_d = state_q; job_d = job_q; ti_d = ti_q; tj_d = tj_q; k_d = k_q;
    rd_pend_d = 1'b0; total_d = total_q;
    acc_d = acc_q; ch_d = ch_q; bit_d = bit_q; num_d = num_q; rem_d = rem_q;
    neg_d = neg_q; res_d = res_q; err_d = err_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    q_s = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    if (rd_pend_q) begin
      total_d = total_q + ikc_pkg::TotBits'(kval);
      for (int c = 0; c < 4; c++) begin
        acc_d[c] = acc_q[c] + ikc_pkg::AccBits'($signed({1'b0,
                   frame_rdata_i[8*c +: 8]}) * kval);
      end
    end
    unique case (state_q)
      ikc_pkg::StIdle: begin
        if (job_valid_i) begin
          job_d = job_i; k_d = ksize_i; ti_d = '0; tj_d = '0;
          total_d = '0; res_d = '0;
          for (int c = 0; c < 4; c++) acc_d[c] = '0;
          if (!ksize_i[0]) begin
            err_d = 1'b1; state_d = ikc_pkg::StOut;
          end else begin
            err_d = 1'b0; state_d = ikc_pkg::StTap;
          end
        end
      end
      ikc_pkg::StTap: begin
        if (!rd_pend_q || ti_q != '0 || tj_q != '0) begin
          rd_pend_d = 1'b1;
          if (ti_q == k_q - 3'd1) begin
            ti_d = '0;
            if (tj_q == k_q - 3'd1) begin
              tj_d = '0; state_d = ikc_pkg::StDiv; ch_d = '0; bit_d = '0;
            end else tj_d = tj_q + 3'd1;
          end else ti_d = ti_q + 3'd1;
        end
      end
      ikc_pkg::StDiv: begin
        if (!rd_pend_q) begin
          if (bit_q == '0) begin
            neg_d = acc_q[ch_q][ikc_pkg::AccBits-1] ^ total_q[ikc_pkg::TotBits-1];
            num_d = acc_q[ch_q][ikc_pkg::AccBits-1] ?
                    ikc_pkg::AccBits'(-acc_q[ch_q]) : ikc_pkg::AccBits'(acc_q[ch_q]);
            rem_d = '0;
            bit_d = (total_q == '0) ? 6'd33 : 6'd1;
          end else if (bit_q <= 6'd32) begin
            if (rem_sh >= dmag) begin
              rem_d = rem_sh - dmag;
              num_d = {num_q[ikc_pkg::AccBits-2:0], 1'b1};
            end else begin
              rem_d = rem_sh;
              num_d = {num_q[ikc_pkg::AccBits-2:0], 1'b0};
            end
            bit_d = bit_q + 6'd1;
          end else begin
            if (total_q == '0) qv = acc_q[ch_q];
            else qv = neg_q ? -$signed(num_q) : $signed(num_q);
            q_s = qv;
            res_d[8*ch_q +: 8] = (q_s < 0) ? 8'd0 : (q_s > 255) ? 8'd255 : q_s[7:0];
            bit_d = '0;
            ch_d = ch_q + 2'd1;
            if (ch_q == 2'd3) state_d = ikc_pkg::StOut;
          end
        end
      end
      ikc_pkg::StOut: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          odata_d = '{pixel_out: err_q ? 32'd0 : res_q, out_x: job_q.pos_x,
                      out_y: job_q.pos_y, size_error: err_q};
          state_d = ikc_pkg::StIdle;
        end
      end
      default: state_d = ikc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ikc_pkg::StIdle;
      ovalid_q <= 1'b0;
      rd_pend_q <= 1'b0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      rd_pend_q <= rd_pend_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; ti_q <= ti_d; tj_q <= tj_d; k_q <= k_d;
    kvld_rd_q <= kvld_q[kidx]; acc_q <= acc_d; ch_q <= ch_d; bit_q <= bit_d;
    num_q <= num_d; rem_q <= rem_d; neg_q <= neg_d; res_q <= res_d;
    err_q <= err_d; odata_q <= odata_d;
  end

endmodule

// ----- hw/rtl/image_kernel_convolver_top.sv -----
// Image kernel convolver.
// The input channel carries one command per transaction: write a kernel
// coefficient, write a packed pixel into the 64 x 64 frame store, or compute
// the filtered pixel at a position. Only compute commands give a result
// transaction on the output channel. Configuration registers are written
// through the plain write port; the user must write them only while the
// block is idle, as the block itself does not enforce it. A front end takes
// writes straight into the stores and queues up to two compute requests.
// The back end walks the k*k window taps through the frame store and kernel
// store read ports, one tap a cycle, summing the coefficients on the way,
// then divides the four channel sums one bit a cycle.
// Writes are held off until the queue is empty and the back end is idle.
// Reset clears the coefficients, the kernel sum and the configuration to
// their defaults; the frame store holds nothing until written.
// When the receiver stalls, the result stays in the output register while
// the next compute proceeds up to its output step.
module image_kernel_convolver_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ikc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ikc_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [6:0]    cfg_data_i
);

  logic [6:0] width_q, height_q;
  logic [2:0] ksize_q;
  logic [1:0] border_q;

  logic                          frame_we;
  logic [ikc_pkg::FrameAw-1:0]   frame_waddr, frame_raddr;
  logic [31:0]                   frame_wdata, frame_rdata;
  logic                          coef_we;
  logic [ikc_pkg::KernAw-1:0]    coef_waddr;
  logic signed [15:0]            coef_wdata;
  logic                          job_valid, job_ready;
  ikc_pkg::job_t                 job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      ksize_q  <= 3'd3;
      border_q <= ikc_pkg::BorderClamp;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ikc_pkg::RegWidth:  width_q  <= cfg_data_i;
        ikc_pkg::RegHeight: height_q <= cfg_data_i;
        ikc_pkg::RegKsize:  ksize_q  <= cfg_data_i[2:0];
        ikc_pkg::RegBorder: border_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ikc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .frame_we_o(frame_we), .frame_waddr_o(frame_waddr), .frame_wdata_o(frame_wdata),
    .coef_we_o(coef_we), .coef_waddr_o(coef_waddr), .coef_wdata_o(coef_wdata),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  ikc_ram #(.Width(32), .Depth(ikc_pkg::FrameDepth)) u_frame (
    .clk_i, .we_i(frame_we), .waddr_i(frame_waddr), .wdata_i(frame_wdata),
    .raddr_i(frame_raddr), .rdata_o(frame_rdata)
  );

  ikc_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .width_i(width_q), .height_i(height_q), .ksize_i(ksize_q), .border_i(border_q),
    .coef_we_i(coef_we), .coef_waddr_i(coef_waddr), .coef_wdata_i(coef_wdata),
    .frame_raddr_o(frame_raddr), .frame_rdata_i(frame_rdata),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
